@@ hdl/bsort_pkg.sv @@
// ----------------------------------------------------------------------------
// bsort_pkg
// Shared types, defaults and helpers for the bitonic batch sorter.
// ----------------------------------------------------------------------------
package bsort_pkg;

   localparam int BATCH_SIZE_DEF = 32;
   localparam int DATA_WIDTH_DEF = 16;
   localparam int BATCH_SIZE_MAX = 256;

   // Wide enough for any stage exponent within the supported batch range.
   localparam int EXP_W = $clog2($clog2(BATCH_SIZE_MAX) + 1);

   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_SORT  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   typedef struct packed {
      logic             shift;
      logic             step;
      logic [EXP_W-1:0] span_exp;
      logic [EXP_W-1:0] dist_exp;
   } cmd_type;

   // Partner lane of a compare-exchange, or the lane itself when out of range.
   function automatic int partner_of(input int lane, input int dist_exp, input int size);
      int p;
      p = lane ^ (1 << dist_exp);
      partner_of = (p < size) ? p : lane;
   endfunction

endpackage

@@ hdl/bsort_datapath.sv @@
// ----------------------------------------------------------------------------
// bsort_datapath
// Element lanes with a shift path for loading and draining and one full
// compare-exchange stage of the bitonic network per step.
// ----------------------------------------------------------------------------
module bsort_datapath
   import bsort_pkg::*;
#(
   parameter int BATCH_SIZE = BATCH_SIZE_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  cmd_type               cmd,
   input  logic [DATA_WIDTH-1:0] in_value,
   output logic [DATA_WIDTH-1:0] head_value
);

   localparam int PHASES = $clog2(BATCH_SIZE + 1) - 1;

   logic [DATA_WIDTH-1:0] elem_ff [BATCH_SIZE];
   logic [DATA_WIDTH-1:0] elem_in [BATCH_SIZE];

   always_comb begin
      logic [DATA_WIDTH-1:0] own;
      logic [DATA_WIDTH-1:0] mate;
      logic                  is_lo;
      logic                  asc;
      logic                  take_mate;
      for (int i = 0; i < BATCH_SIZE; i++) begin
         own  = elem_ff[i];
         mate = own;
         for (int j = 0; j < PHASES; j++) begin
            if (cmd.dist_exp == EXP_W'(j)) begin
               mate = elem_ff[partner_of(i, j, BATCH_SIZE)];
            end
         end
         is_lo = ((i >> cmd.dist_exp) & 1) == 0;
         asc   = ((i >> cmd.span_exp) & 1) == 0;
         if (is_lo) begin
            take_mate = asc ? (own > mate) : (own < mate);
         end else begin
            take_mate = asc ? (mate > own) : (mate < own);
         end
         priority if (cmd.shift) begin
            elem_in[i] = (i == BATCH_SIZE - 1) ? in_value : elem_ff[(i + 1) % BATCH_SIZE];
         end else if (cmd.step) begin
            elem_in[i] = take_mate ? mate : own;
         end else begin
            elem_in[i] = own;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BATCH_SIZE; i++) begin
         elem_ff[i] <= elem_in[i];
      end
   end

   assign head_value = elem_ff[0];

endmodule

@@ hdl/bsort_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsort_ctrl
// Sequencer for loading, the network stages and draining of one batch.
// ----------------------------------------------------------------------------
module bsort_ctrl
   import bsort_pkg::*;
#(
   parameter int BATCH_SIZE = BATCH_SIZE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output logic    out_last,
   output cmd_type cmd
);

   localparam int PHASES = $clog2(BATCH_SIZE + 1) - 1;
   localparam int CNT_W  = $clog2(BATCH_SIZE);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [EXP_W-1:0] span_ff, span_in;
   logic [EXP_W-1:0] dist_ff, dist_in;
   logic             in_take;
   logic             out_take;
   logic             count_end;

   assign in_ready  = (state_ff == ST_LOAD);
   assign out_valid = (state_ff == ST_DRAIN);
   assign in_take   = in_valid && in_ready;
   assign out_take  = out_valid && out_ready;
   assign count_end = (count_ff == CNT_W'(BATCH_SIZE - 1));
   assign out_last  = count_end;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      span_in  = span_ff;
      dist_in  = dist_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (in_take) begin
               count_in = count_end ? '0 : count_ff + 1'b1;
               if (count_end) begin
                  state_in = ST_SORT;
                  span_in  = EXP_W'(1);
                  dist_in  = '0;
               end
            end
         end
         ST_SORT: begin
            if (dist_ff == '0) begin
               if (span_ff == EXP_W'(PHASES)) begin
                  state_in = ST_DRAIN;
               end else begin
                  span_in = span_ff + 1'b1;
                  dist_in = span_ff;
               end
            end else begin
               dist_in = dist_ff - 1'b1;
            end
         end
         ST_DRAIN: begin
            if (out_take) begin
               count_in = count_end ? '0 : count_ff + 1'b1;
               if (count_end) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         span_ff  <= '0;
         dist_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         span_ff  <= span_in;
         dist_ff  <= dist_in;
      end
   end

   always_comb begin
      cmd.shift    = in_take || out_take;
      cmd.step     = (state_ff == ST_SORT);
      cmd.span_exp = span_ff;
      cmd.dist_exp = dist_ff;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(in_ready && out_valid))
      else $error("Loading and draining are active together.");

   a_full_starts_sort: assert property (@(posedge clock) disable iff (reset)
      (in_take && count_end) |=> (state_ff == ST_SORT))
      else $error("A full batch did not start the network.");

   a_drain_ends_load: assert property (@(posedge clock) disable iff (reset)
      (out_take && out_last) |=> (in_ready && count_ff == '0))
      else $error("The last result did not return the block to loading.");

   a_sort_no_shift: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !cmd.shift)
      else $error("Element lanes shifted during a network stage.");

endmodule

@@ hdl/bitonic_sorter_32.sv @@
// ----------------------------------------------------------------------------
// bitonic_sorter_32
// Batch sorter built on a bitonic compare-exchange network.
// ----------------------------------------------------------------------------
// The block takes BATCH_SIZE unsigned values, one request per cycle, then
// runs the bitonic network, one full compare-exchange stage per cycle, and
// then returns the batch in ascending order, one value per cycle while the
// receiver is ready, with tlast on the largest. Requests are refused while
// a batch sorts or drains, since the single set of element lanes loads,
// sorts and drains in turn.
module bitonic_sorter_32
   import bsort_pkg::*;
#(
   parameter int BATCH_SIZE = BATCH_SIZE_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((DATA_WIDTH + 7) / 8)*8-1:0] req_tdata,  // sample_value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((DATA_WIDTH + 7) / 8)*8-1:0] rsp_tdata,  // sorted_value
   output logic                                rsp_tlast   // last_of_batch
);

   localparam int BUS_W = ((DATA_WIDTH + 7) / 8) * 8;

   cmd_type               cmd;
   logic [DATA_WIDTH-1:0] head_value;

   bsort_ctrl #(
      .BATCH_SIZE(BATCH_SIZE)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_last (rsp_tlast),
      .cmd      (cmd)
   );

   bsort_datapath #(
      .BATCH_SIZE(BATCH_SIZE),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .in_value  (req_tdata[DATA_WIDTH-1:0]),
      .head_value(head_value)
   );

   assign rsp_tdata = BUS_W'(head_value);

endmodule

@@ dv/bitonic_sorter_32_checker.sv @@
// ----------------------------------------------------------------------------
// bitonic_sorter_32_checker
// Watches both streams of the batch sorter and checks every sorted value.
// ----------------------------------------------------------------------------
// Accepted requests are collected into a batch. When a batch is full, it is
// put through a bitonic compare-exchange network of its own, and the sorted
// values are queued with the expected tlast. Each accepted response is then
// checked against the oldest queued value.
module bitonic_sorter_32_checker
   import bsort_pkg::*;
#(
   parameter int BATCH_SIZE = BATCH_SIZE_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [((DATA_WIDTH + 7) / 8)*8-1:0] req_tdata,  // sample_value
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [((DATA_WIDTH + 7) / 8)*8-1:0] rsp_tdata,  // sorted_value
   input  logic                                rsp_tlast,  // last_of_batch
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  batch_count,
   output int                                  response_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      logic                  last;
   } sorted_entry_type;

   logic [DATA_WIDTH-1:0] batch_lanes [BATCH_SIZE];
   int                    fill_level;
   sorted_entry_type      sorted_expect [$];

   function automatic void sort_batch_lanes();
      int                    span;
      int                    gap;
      int                    partner;
      logic [DATA_WIDTH-1:0] lo_val;
      logic [DATA_WIDTH-1:0] hi_val;
      bit                    ascending;
      for (span = 2; span <= BATCH_SIZE; span = span << 1) begin
         for (gap = span >> 1; gap > 0; gap = gap >> 1) begin
            for (int lane = 0; lane < BATCH_SIZE; lane++) begin
               partner = lane ^ gap;
               if (partner > lane && partner < BATCH_SIZE) begin
                  lo_val    = batch_lanes[lane];
                  hi_val    = batch_lanes[partner];
                  ascending = ((lane & span) == 0);
                  if (ascending ? (lo_val > hi_val) : (lo_val < hi_val)) begin
                     batch_lanes[lane]    = hi_val;
                     batch_lanes[partner] = lo_val;
                  end
               end
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      sorted_entry_type oldest;
      if (reset) begin
         fill_level = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            batch_lanes[fill_level] = req_tdata[DATA_WIDTH-1:0];
            fill_level++;
            if (fill_level == BATCH_SIZE) begin
               sort_batch_lanes();
               for (int k = 0; k < BATCH_SIZE; k++) begin
                  sorted_expect.push_back('{value: batch_lanes[k],
                                            last: (k == BATCH_SIZE - 1)});
               end
               fill_level = 0;
               batch_count++;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            response_count++;
            if (sorted_expect.size() == 0) begin
               $error("unexpected response: sorted_value 0x%h last_of_batch %b",
                      rsp_tdata[DATA_WIDTH-1:0], rsp_tlast);
               fail_count++;
            end else begin
               oldest = sorted_expect.pop_front();
               if (rsp_tdata[DATA_WIDTH-1:0] !== oldest.value) begin
                  $error("sorted_value mismatch: expected 0x%h, actual 0x%h",
                         oldest.value, rsp_tdata[DATA_WIDTH-1:0]);
                  fail_count++;
               end
               if (rsp_tlast !== oldest.last) begin
                  $error("last_of_batch mismatch: expected %b, actual %b",
                         oldest.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
      pending_count = sorted_expect.size();
   end

endmodule

@@ dv/tb_bitonic_sorter_32.sv @@
// ----------------------------------------------------------------------------
// tb_bitonic_sorter_32
// Stimulus and verdict for the 32-value bitonic batch sorter.
// ----------------------------------------------------------------------------
// A directed batch with extreme values, duplicates and a descending run is
// followed by random batches of several shapes. Both stream sides stall at
// random, with one batch sent and drained with no stall, and the sender
// holds back after two batches until every sorted value has come out. The
// checker module predicts and compares; this module only drives and reports.
module tb_bitonic_sorter_32
   import bsort_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 4;
   localparam int BATCH          = BATCH_SIZE_DEF;
   localparam int DATA_W         = DATA_WIDTH_DEF;
   localparam int TDATA_W        = ((DATA_W + 7) / 8) * 8;
   localparam int RANDOM_BATCHES = 5;
   localparam int IDLE_PCT       = 36;
   localparam int SETTLE_CYCLES  = 2 * BATCH + 40;
   localparam int STALL_LIMIT    = 2000;

   typedef enum int {
      SHAPE_UNIFORM,
      SHAPE_NARROW,
      SHAPE_ASCENDING,
      SHAPE_DESCENDING,
      SHAPE_CONSTANT,
      SHAPE_EXTREMES
   } batch_shape_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic               rsp_tlast;

   int fail_count;
   int pending_count;
   int batch_count;
   int response_count;
   int send_idle_pct = IDLE_PCT;
   int recv_idle_pct = IDLE_PCT;
   int stall_cycles  = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   bitonic_sorter_32 #(
      .BATCH_SIZE (BATCH),
      .DATA_WIDTH (DATA_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   bitonic_sorter_32_checker #(
      .BATCH_SIZE (BATCH),
      .DATA_WIDTH (DATA_W)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .batch_count    (batch_count),
      .response_count (response_count)
   );

   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_sample(input logic [DATA_W-1:0] value);
      bit accepted;
      accepted = 1'b0;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_W'(value);
      while (!accepted) begin
         @(posedge clock);
         accepted = req_tready;
      end
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [DATA_W-1:0] directed_value(input int idx);
      case (idx)
         0:         directed_value = 16'hFFFF;
         1:         directed_value = 16'h0000;
         2:         directed_value = 16'h8000;
         3:         directed_value = 16'h7FFF;
         4:         directed_value = 16'h0001;
         5:         directed_value = 16'hFFFE;
         6:         directed_value = 16'h5555;
         7:         directed_value = 16'hAAAA;
         8, 9, 10:  directed_value = 16'h1234;
         11:        directed_value = 16'h0000;
         12:        directed_value = 16'hFFFF;
         default:   directed_value = DATA_W'(16'hF000 - idx * 16'h0111);
      endcase
   endfunction

   task automatic send_batch(input batch_shape_type shape);
      logic [DATA_W-1:0] base;
      logic [DATA_W-1:0] value;
      int                step;
      base = DATA_W'($urandom);
      step = $urandom_range(1, 600);
      for (int k = 0; k < BATCH; k++) begin
         case (shape)
            SHAPE_UNIFORM:    value = DATA_W'($urandom);
            SHAPE_NARROW:     value = base + DATA_W'($urandom_range(0, 3));
            SHAPE_ASCENDING:  value = base + DATA_W'(k * step);
            SHAPE_DESCENDING: value = base - DATA_W'(k * step);
            SHAPE_CONSTANT:   value = base;
            default:          value = $urandom_range(0, 1) ? '1 : '0;
         endcase
         send_sample(value);
      end
   endtask

   initial begin
      batch_shape_type shape;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < BATCH; k++) begin
         send_sample(directed_value(k));
      end

      for (int r = 0; r < RANDOM_BATCHES; r++) begin
         if (r == 0 || $urandom_range(0, 1) == 0) begin
            shape = SHAPE_UNIFORM;
         end else begin
            shape = batch_shape_type'($urandom_range(SHAPE_NARROW, SHAPE_EXTREMES));
         end
         if (r == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_batch(shape);
         if (r == 1 || r == 2) begin
            hold_until_drained();
         end
         send_idle_pct = IDLE_PCT;
         recv_idle_pct = IDLE_PCT;
      end

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sorted %0d batches of %0d values, %0d responses checked.",
               batch_count, BATCH, response_count);
      $display("Covered extremes, duplicates, ramps, constant runs and random stalls.");
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/bsort_pkg.sv
hdl/bsort_datapath.sv
hdl/bsort_ctrl.sv
hdl/bitonic_sorter_32.sv
dv/bitonic_sorter_32_checker.sv
dv/tb_bitonic_sorter_32.sv
